### hdl/fltr_pkg.sv
package fltr_pkg;

    localparam int POOL_NODES = 4096;
    localparam int ALPHABET   = 26;
    localparam int WORD_LEN   = 5;
    localparam int NODE_W     = $clog2(POOL_NODES);
    localparam int NFREE_W    = NODE_W + 1;
    localparam int SLOT_W     = $clog2(POOL_NODES * ALPHABET);
    localparam int LET_W      = $clog2(ALPHABET);
    localparam int CNT_W      = $clog2(ALPHABET + 1);
    localparam int LVL_W      = $clog2(WORD_LEN + 1);
    localparam logic [7:0] BASE_CHAR = 8'd97;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_PICK   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_LETTER = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] letter_0;
        logic [7:0] letter_1;
        logic [7:0] letter_2;
        logic [7:0] letter_3;
        logic [7:0] letter_4;
        logic [4:0] rand_0;
        logic [4:0] rand_1;
        logic [4:0] rand_2;
        logic [4:0] rand_3;
        logic [4:0] rand_4;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] pick_0;
        logic [7:0] pick_1;
        logic [7:0] pick_2;
        logic [7:0] pick_3;
        logic [7:0] pick_4;
    } t_out;

    typedef struct packed {
        logic [ALPHABET-1:0] present;
        logic [CNT_W-1:0]    count;
    } t_meta;

    typedef struct packed {
        logic              meta_we;
        logic [NODE_W-1:0] meta_addr;
        t_meta             meta_wdata;
        logic              ptr_we;
        logic [SLOT_W-1:0] ptr_addr;
        logic [NODE_W-1:0] ptr_wdata;
    } t_mem_req;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                  input logic [LET_W-1:0] letter);
        logic [SLOT_W-1:0] s;
        s = SLOT_W'(node) * SLOT_W'(ALPHABET) + SLOT_W'(letter);
        return s;
    endfunction

endpackage

### hdl/fltr_mem.sv
module fltr_mem (
    input  logic                     i_clk,
    input  fltr_pkg::t_mem_req       i_req,
    output fltr_pkg::t_meta          o_meta,
    output logic [fltr_pkg::NODE_W-1:0] o_ptr
);
    import fltr_pkg::*;

    t_meta             r_meta_mem [POOL_NODES];
    logic [NODE_W-1:0] r_ptr_mem  [POOL_NODES * ALPHABET];

    always_ff @(posedge i_clk) begin
        if (i_req.meta_we) begin
            r_meta_mem[i_req.meta_addr] <= i_req.meta_wdata;
        end
        o_meta <= r_meta_mem[i_req.meta_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ptr_we) begin
            r_ptr_mem[i_req.ptr_addr] <= i_req.ptr_wdata;
        end
        o_ptr <= r_ptr_mem[i_req.ptr_addr];
    end

endmodule

### hdl/fltr_kth.sv
module fltr_kth (
    input  logic [fltr_pkg::ALPHABET-1:0] i_present,
    input  logic [fltr_pkg::CNT_W-1:0]    i_rank,
    output logic [fltr_pkg::LET_W-1:0]    o_idx,
    output logic                          o_hit
);
    import fltr_pkg::*;

    logic [CNT_W-1:0] below [ALPHABET];

    always_comb begin
        o_idx = '0;
        o_hit = 1'b0;
        for (int j = 0; j < ALPHABET; j++) begin
            below[j] = CNT_W'($countones(i_present & ((ALPHABET'(1) << j) - ALPHABET'(1))));
            if (i_present[j] && below[j] == i_rank) begin
                o_idx = LET_W'(j);
                o_hit = 1'b1;
            end
        end
    end

endmodule

### hdl/five_letter_trie_engine.sv
// insert and look up walk the matched levels, and insert then builds each new node;
// a bad letter or an unused op goes straight to the result
// pick walks the trie one level at a time; one item at a time,
// the next transfer in is taken in the cycle after the result is registered
// the node store memories set the pace: one registered read per access
// a result waiting at the output does not block the next transfer in
// reset (synchronous, active low) empties the trie at once; node memories are not swept
module five_letter_trie_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fltr_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fltr_pkg::t_out   o_out
);
    import fltr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_WEVAL, S_BUILD, S_LEAF,
        S_PRD, S_PEV, S_PPTR, S_PNODE, S_DONE
    } t_state;

    t_state             r_state;
    logic [1:0]         r_op;
    logic [LET_W-1:0]   r_off  [WORD_LEN];
    logic [4:0]         r_rand [WORD_LEN];
    logic [7:0]         r_pick [WORD_LEN];
    logic [NODE_W-1:0]  r_node;
    logic [LVL_W-1:0]   r_level;
    t_meta              r_meta;
    logic [NFREE_W-1:0] r_next_free;
    logic [LET_W-1:0]   r_sel;
    logic [1:0]         r_status;
    logic               r_found;

    t_mem_req           mem_req;
    t_meta              rd_meta;
    logic [NODE_W-1:0]  rd_ptr;
    t_meta              meta_eff;
    logic [7:0]         letters [WORD_LEN];
    logic [LET_W-1:0]   offs    [WORD_LEN];
    logic               letters_ok;
    logic [CNT_W-1:0]   rank;
    logic [LET_W-1:0]   kth_idx;
    logic               kth_hit;
    logic [NFREE_W-1:0] need;
    logic               out_free;

    fltr_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_meta (rd_meta),
        .o_ptr  (rd_ptr)
    );

    fltr_kth u_kth (
        .i_present (meta_eff.present),
        .i_rank    (rank),
        .o_idx     (kth_idx),
        .o_hit     (kth_hit)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    always_comb begin
        letters[0] = i_in.letter_0;
        letters[1] = i_in.letter_1;
        letters[2] = i_in.letter_2;
        letters[3] = i_in.letter_3;
        letters[4] = i_in.letter_4;
        letters_ok = 1'b1;
        for (int i = 0; i < WORD_LEN; i++) begin
            offs[i] = LET_W'(letters[i] - BASE_CHAR);
            if (letters[i] < BASE_CHAR || (letters[i] - BASE_CHAR) >= 8'(ALPHABET)) begin
                letters_ok = 1'b0;
            end
        end
    end

    // nodes at or past the free mark, and the root before any insert, read as empty
    always_comb begin
        if (r_node < r_next_free[NODE_W-1:0] || r_next_free > NFREE_W'(POOL_NODES - 1)) begin
            meta_eff = (r_next_free != NFREE_W'(1)) ? rd_meta : '0;
        end else begin
            meta_eff = '0;
        end
        if (r_node >= r_next_free[NODE_W-1:0] && r_next_free <= NFREE_W'(POOL_NODES - 1)) begin
            meta_eff = '0;
        end
    end

    always_comb begin
        rank = CNT_W'(r_rand[r_level[2:0]]);
        if (meta_eff.count != '0 && rank > meta_eff.count - CNT_W'(1)) begin
            rank = meta_eff.count - CNT_W'(1);
        end
    end

    assign need = NFREE_W'(WORD_LEN) - NFREE_W'(r_level);

    always_comb begin
        mem_req            = '0;
        mem_req.meta_addr  = r_node;
        mem_req.ptr_addr   = slot_of(r_node, r_off[r_level[2:0]]);
        mem_req.ptr_wdata  = r_next_free[NODE_W-1:0];
        unique case (r_state)
            S_BUILD: begin
                mem_req.meta_we    = 1'b1;
                mem_req.meta_wdata.present = r_meta.present
                                           | (ALPHABET'(1) << r_off[r_level[2:0]]);
                mem_req.meta_wdata.count   = r_meta.count + CNT_W'(1);
                mem_req.ptr_we     = 1'b1;
            end
            S_LEAF: begin
                mem_req.meta_we    = 1'b1;
            end
            S_PPTR: begin
                mem_req.ptr_addr   = slot_of(r_node, r_sel);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= NFREE_W'(1);
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_in.op;
                        r_off    <= offs;
                        r_rand[0] <= i_in.rand_0;
                        r_rand[1] <= i_in.rand_1;
                        r_rand[2] <= i_in.rand_2;
                        r_rand[3] <= i_in.rand_3;
                        r_rand[4] <= i_in.rand_4;
                        for (int i = 0; i < WORD_LEN; i++) begin
                            r_pick[i] <= '0;
                        end
                        r_node   <= '0;
                        r_level  <= '0;
                        r_found  <= 1'b0;
                        if (i_in.op == OP_INSERT || i_in.op == OP_LOOKUP) begin
                            if (letters_ok) begin
                                r_status <= ST_OK;
                                r_state  <= S_WALK;
                            end else begin
                                r_status <= ST_BAD_LETTER;
                                r_state  <= S_DONE;
                            end
                        end else if (i_in.op == OP_PICK) begin
                            r_status <= ST_OK;
                            r_state  <= S_PRD;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_WALK: begin
                    if (r_level == LVL_W'(WORD_LEN)) begin
                        r_found <= (r_op == OP_LOOKUP);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WEVAL;
                    end
                end
                S_WEVAL: begin
                    if (meta_eff.present[r_off[r_level[2:0]]]) begin
                        r_node  <= rd_ptr;
                        r_level <= r_level + LVL_W'(1);
                        r_state <= S_WALK;
                    end else if (r_op == OP_LOOKUP) begin
                        r_state <= S_DONE;
                    end else if (r_next_free > NFREE_W'(POOL_NODES)
                                 || NFREE_W'(POOL_NODES) - r_next_free < need) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_meta  <= meta_eff;
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    r_node      <= r_next_free[NODE_W-1:0];
                    r_next_free <= r_next_free + NFREE_W'(1);
                    r_meta      <= '0;
                    r_level     <= r_level + LVL_W'(1);
                    r_state     <= (r_level == LVL_W'(WORD_LEN - 1)) ? S_LEAF : S_BUILD;
                end
                S_LEAF: begin
                    r_state <= S_DONE;
                end
                S_PRD: begin
                    r_state <= S_PEV;
                end
                S_PEV: begin
                    if (meta_eff.count == '0 || !kth_hit) begin
                        if (r_level == '0) begin
                            r_status <= ST_EMPTY;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_pick[r_level[2:0]] <= BASE_CHAR + 8'(kth_idx);
                        r_sel   <= kth_idx;
                        r_state <= S_PPTR;
                    end
                end
                S_PPTR: begin
                    r_state <= S_PNODE;
                end
                S_PNODE: begin
                    r_node  <= rd_ptr;
                    r_level <= r_level + LVL_W'(1);
                    r_state <= (r_level == LVL_W'(WORD_LEN - 1)) ? S_DONE : S_PRD;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out.status <= r_status;
                        o_out.found  <= r_found;
                        o_out.pick_0 <= r_pick[0];
                        o_out.pick_1 <= r_pick[1];
                        o_out.pick_2 <= r_pick[2];
                        o_out.pick_3 <= r_pick[3];
                        o_out.pick_4 <= r_pick[4];
                        o_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/tb_five_letter_trie_engine.sv
`timescale 1ns / 1ps

module tb_five_letter_trie_engine;
    import fltr_pkg::*;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_in    i_in;
    logic   o_out_valid;
    logic   i_out_stall;
    t_out   o_out;

    five_letter_trie_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // shadow trie
    logic [NODE_W-1:0]   trie_ptr [POOL_NODES*ALPHABET];
    logic [ALPHABET-1:0] trie_present [POOL_NODES];
    int unsigned         trie_count [POOL_NODES];
    int unsigned         free_node;

    t_out expected_results [$];
    int   mismatches;
    bit   hold_off;
    bit   calm_output;

    // stored words, used to build lookups and duplicate inserts
    logic [7:0] stored_words [$][5];

    function automatic t_out trie_apply(input t_in item);
        t_out r;
        logic [7:0] w [5];
        int unsigned off [5];
        int unsigned node;
        int unsigned depth;
        int unsigned k;
        int unsigned fresh;
        bit ok;
        bit taken;
        r = '0;
        w = '{item.letter_0, item.letter_1, item.letter_2, item.letter_3, item.letter_4};
        node = 0;
        if (item.op == OP_INSERT || item.op == OP_LOOKUP) begin
            ok = 1'b1;
            for (int i = 0; i < 5; i++) begin
                if (w[i] < BASE_CHAR || w[i] - BASE_CHAR >= ALPHABET) ok = 1'b0;
                else off[i] = w[i] - BASE_CHAR;
            end
            if (!ok) begin
                r.status = ST_BAD_LETTER;
                return r;
            end
            depth = 0;
            while (depth < 5 && trie_present[node][off[depth]]) begin
                node = trie_ptr[node*ALPHABET + off[depth]];
                depth++;
            end
            if (item.op == OP_LOOKUP) begin
                r.found = (depth == 5);
                return r;
            end
            if (free_node > POOL_NODES || POOL_NODES - free_node < 5 - depth) begin
                r.status = ST_FULL;
                return r;
            end
            if (depth < 5) stored_words.push_back(w);
            while (depth < 5) begin
                fresh = free_node;
                free_node++;
                trie_ptr[node*ALPHABET + off[depth]] = NODE_W'(fresh);
                trie_present[node][off[depth]] = 1'b1;
                trie_count[node]++;
                node = fresh;
                depth++;
            end
            return r;
        end
        if (item.op == OP_PICK) begin
            if (trie_count[0] == 0) begin
                r.status = ST_EMPTY;
                return r;
            end
            w = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
            for (int i = 0; i < 5; i++) begin
                if (trie_count[node] == 0) break;
                case (i)
                    0: k = item.rand_0;
                    1: k = item.rand_1;
                    2: k = item.rand_2;
                    3: k = item.rand_3;
                    default: k = item.rand_4;
                endcase
                if (k > trie_count[node] - 1) k = trie_count[node] - 1;
                taken = 1'b0;
                for (int j = 0; j < ALPHABET; j++) begin
                    if (trie_present[node][j]) begin
                        if (k == 0) begin
                            w[i] = 8'(BASE_CHAR + j);
                            node = trie_ptr[node*ALPHABET + j];
                            taken = 1'b1;
                            break;
                        end
                        k--;
                    end
                end
                if (!taken) break;
            end
            {r.pick_0, r.pick_1, r.pick_2, r.pick_3, r.pick_4} = {w[0], w[1], w[2], w[3], w[4]};
        end
        return r;
    endfunction

    task automatic send_item(input t_in item);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (calm_output) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(trie_apply(item));
        @(negedge i_clk);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off) begin
            i_out_stall <= 1'b1;
        end else if (calm_output) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer %p", o_out);
            end else begin
                want = expected_results.pop_front();
                if (o_out.status !== want.status || o_out.found !== want.found ||
                    o_out.pick_0 !== want.pick_0 || o_out.pick_1 !== want.pick_1 ||
                    o_out.pick_2 !== want.pick_2 || o_out.pick_3 !== want.pick_3 ||
                    o_out.pick_4 !== want.pick_4) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, o_out);
                end
            end
        end
    end

    function automatic t_in make_item(input logic [1:0] op, input logic [7:0] w [5]);
        t_in item;
        item.op = op;
        {item.letter_0, item.letter_1, item.letter_2, item.letter_3, item.letter_4} =
            {w[0], w[1], w[2], w[3], w[4]};
        {item.rand_0, item.rand_1, item.rand_2, item.rand_3, item.rand_4} = '0;
        return item;
    endfunction

    function automatic t_in random_word_item(input logic [1:0] op, input int letters);
        logic [7:0] w [5];
        for (int i = 0; i < 5; i++) w[i] = 8'(BASE_CHAR + $urandom_range(0, letters - 1));
        return make_item(op, w);
    endfunction

    task automatic test_empty_and_letters();
        t_in item;
        logic [7:0] w [5];
        item = '0;
        item.op = OP_PICK;
        send_item(item);
        item.rand_0 = 5'd31;
        item.rand_4 = 5'd31;
        send_item(item);
        w = '{"a", "a", "a", "a", "a"};
        send_item(make_item(OP_LOOKUP, w));
        send_item(make_item(OP_INSERT, w));
        send_item(make_item(OP_INSERT, w));
        send_item(make_item(OP_LOOKUP, w));
        w = '{"z", "z", "z", "z", "z"};
        send_item(make_item(OP_INSERT, w));
        send_item(make_item(OP_LOOKUP, w));
        w = '{"a", "a", "a", "a", "b"};
        send_item(make_item(OP_LOOKUP, w));
        for (int i = 0; i < 5; i++) begin
            w = '{"c", "c", "c", "c", "c"};
            w[i] = (i % 2) ? 8'h7b : 8'h60;
            send_item(make_item(i % 2 ? OP_LOOKUP : OP_INSERT, w));
        end
        w = '{8'hff, 8'h00, "a", "a", "a"};
        send_item(make_item(OP_INSERT, w));
        w = '{"a", "a", "a", "a", "a"};
        item = make_item(2'd3, w);
        send_item(item);
        item = make_item(OP_PICK, w);
        item.letter_0 = 8'hff;
        send_item(item);
        {item.rand_0, item.rand_1, item.rand_2, item.rand_3, item.rand_4} = '1;
        send_item(item);
        item.rand_0 = 5'd1;
        item.rand_1 = 5'd0;
        send_item(item);
    endtask

    task automatic test_random_mix(input int count);
        t_in item;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                item = random_word_item(OP_INSERT, $urandom_range(0, 1) ? 3 : 26);
            end else if (sel < 55 && stored_words.size() > 0) begin
                item = make_item(OP_LOOKUP,
                    stored_words[$urandom_range(0, stored_words.size() - 1)]);
                if ($urandom_range(0, 3) == 0) item.op = OP_INSERT;
            end else if (sel < 65) begin
                item = random_word_item(OP_LOOKUP, 3);
            end else if (sel < 88) begin
                item = t_in'({$urandom(), $urandom()});
                item.op = OP_PICK;
                {item.rand_0, item.rand_1, item.rand_2, item.rand_3, item.rand_4} =
                    $urandom_range(0, 1) ? {5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)),
                    5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)),
                    5'($urandom_range(0, 3))}
                    : 25'($urandom());
            end else begin
                item = t_in'({$urandom(), $urandom()});
            end
            send_item(item);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            test_random_mix(30);
        join
    endtask

    // fill the pool with distinct words, then check full and duplicate handling
    task automatic test_pool_full();
        t_in item;
        int unsigned idx;
        logic [7:0] w [5];
        calm_output = 1'b1;
        idx = 0;
        while (free_node + 5 <= POOL_NODES) begin
            idx++;
            for (int i = 0; i < 5; i++) w[i] = 8'(BASE_CHAR + (idx / (26 ** i)) % 26);
            w[4] = "q";
            send_item(make_item(OP_INSERT, w));
        end
        calm_output = 1'b0;
        w = '{"x", "y", "x", "y", "x"};
        send_item(make_item(OP_INSERT, w));
        send_item(make_item(OP_LOOKUP, w));
        send_item(make_item(OP_INSERT, stored_words[0]));
        send_item(make_item(OP_LOOKUP, stored_words[$]));
        test_random_mix(40);
    endtask

    initial begin
        int waited;
        mismatches  = 0;
        hold_off    = 1'b0;
        calm_output = 1'b0;
        free_node   = 1;
        for (int i = 0; i < POOL_NODES; i++) begin
            trie_present[i] = '0;
            trie_count[i]   = 0;
        end
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_and_letters();
        test_random_mix(300);
        test_backpressure();
        test_pool_full();
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("five_letter_trie_engine verification clean");
        end else begin
            $display("five_letter_trie_engine verification failed");
        end
        $finish;
    end

    initial begin
        #12ms;
        $display("five_letter_trie_engine verification failed");
        $finish;
    end

endmodule
